// File: hw/rtl/hetr_pkg.sv
// Shared types and constants of the hashed entry table.
package hetr_pkg;

   // Bound kinds of an entry.
   localparam logic [1:0] BOUND_NONE  = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;
   localparam logic [1:0] BOUND_EXACT = 2'd3;

   // Request modes.
   localparam logic MODE_PROBE = 1'b0;
   localparam logic MODE_STORE = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_GENERATION     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATE_THRESHOLD = 1'd1;

   localparam logic [7:0]  GENERATION_RESET     = 8'd0;
   localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd31744;

   // Margin that lets a store of the same position replace a slightly deeper entry.
   localparam logic signed [9:0] SAME_LOCK_MARGIN = 10'sd3;

   typedef struct packed {
      logic               mode;
      logic [63:0]        key;
      logic [15:0]        move_code;
      logic signed [15:0] score;
      logic signed [15:0] static_eval;
      logic signed [7:0]  search_depth;
      logic [1:0]         bound_kind;
      logic [7:0]         ply;
   } req_word_type;

   typedef struct packed {
      logic               hit;
      logic [15:0]        hit_move;
      logic signed [15:0] hit_score;
      logic signed [15:0] hit_eval;
      logic signed [7:0]  hit_depth;
      logic [1:0]         hit_bound;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic index_step;
      logic mem_read;
      logic commit;
      logic clear_write;
   } cmd_type;

   typedef struct packed {
      logic index_ready;
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/hetr_ctrl.sv
// Controller state machine that sequences clearing, lookup and commit.
module hetr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hetr_pkg::status_type status,
   output hetr_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;
   localparam logic [1:0] S_EVAL   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            // The slot index may still be forming; read the slot once it is known.
            if (status.index_ready) begin
               cmd.mem_read = 1'b1;
               state_in     = S_EVAL;
            end else begin
               cmd.index_step = 1'b1;
            end
         end
         S_EVAL: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: hw/rtl/hetr_dpath.sv
// Datapath: request register, slot index, table memory, replacement logic and result register.
module hetr_dpath #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int LOCK_BITS     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hetr_pkg::req_word_type              req_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output hetr_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_write,
   input  logic [hetr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hetr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  hetr_pkg::cmd_type                   cmd,
   output hetr_pkg::status_type                status
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic [LOCK_BITS-1:0] lock;
      logic [7:0]           gen;
      logic signed [7:0]    depth;
      logic [1:0]           bound;
      logic [15:0]          move;
      logic signed [15:0]   score;
      logic signed [15:0]   eval;
   } entry_type;

   // Mate scores move by ply: into the table away from zero, out of it back toward zero.
   function automatic logic signed [15:0] adjust_score(
      input logic signed [15:0] s,
      input logic [7:0]         ply,
      input logic [14:0]        thr,
      input logic               into
   );
      logic signed [17:0] s_w;
      logic signed [17:0] t_w;
      logic signed [17:0] d_w;
      logic signed [17:0] sum;
      s_w = {{2{s[15]}}, s};
      t_w = {3'b000, thr};
      d_w = into ? {10'd0, ply} : -{10'd0, ply};
      if (s_w >= t_w) begin
         sum = s_w + d_w;
      end else if (s_w <= -t_w) begin
         sum = s_w - d_w;
      end else begin
         sum = s_w;
      end
      if (sum > 18'sd32767) begin
         adjust_score = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         adjust_score = 16'sh8000;
      end else begin
         adjust_score = sum[15:0];
      end
   endfunction

   hetr_pkg::req_word_type req_ff;
   logic [7:0]             generation_ff;
   logic [14:0]            mate_threshold_ff;
   logic [IDX_W-1:0]       clr_ff;
   logic [IDX_W-1:0]       idx;
   logic                   idx_ready;
   entry_type              mem [TABLE_ENTRIES];
   entry_type              rd_ff;
   entry_type              wr_entry;
   logic [IDX_W-1:0]       wr_addr;
   logic                   mem_we;
   logic [LOCK_BITS-1:0]   req_lock;
   logic                   lock_eq;
   logic                   store_ok;
   logic signed [9:0]      new_depth_w;
   logic signed [9:0]      old_depth_w;
   logic                   rsp_valid_ff;
   hetr_pkg::rsp_word_type rsp_data_ff;
   hetr_pkg::rsp_word_type rsp_data_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         generation_ff     <= hetr_pkg::GENERATION_RESET;
         mate_threshold_ff <= hetr_pkg::MATE_THRESHOLD_RESET;
      end else if (csr_write) begin
         if (csr_index == hetr_pkg::CSR_GENERATION) begin
            generation_ff <= csr_wdata[7:0];
         end else if (csr_index == hetr_pkg::CSR_MATE_THRESHOLD) begin
            mate_threshold_ff <= csr_wdata[14:0];
         end
      end
   end

   // Slot index: the low key bits for a power-of-two table. Otherwise each key bit i
   // weighs 2**i mod TABLE_ENTRIES; eight weighted bits are added per step, and the
   // sum, below 64 times the table size, is then brought under the table size by
   // compare and subtract against shifted copies of it, one copy per step.
   generate
      if (IS_POW2) begin : g_idx_mask
         logic [IDX_W-1:0] idx_ff;
         always_ff @(posedge clock) begin
            if (cmd.capture) begin
               idx_ff <= req_data.key[IDX_W-1:0];
            end
         end
         assign idx       = idx_ff;
         assign idx_ready = 1'b1;
      end else begin : g_idx_mod
         localparam int ACC_W = IDX_W + 6;
         localparam logic [63:0]      MOD64      = 64'(TABLE_ENTRIES);
         localparam logic [ACC_W-1:0] MOD_ACC    = ACC_W'(TABLE_ENTRIES);
         localparam logic [3:0]       STEP_COUNT = 4'd14;
         localparam logic [3:0]       FOLD_FIRST = 4'd7;
         logic [IDX_W-1:0] bit_weight [64];
         logic [ACC_W-1:0] acc_ff;
         logic [ACC_W-1:0] acc_in;
         logic [ACC_W-1:0] group_sum;
         logic [ACC_W-1:0] sub_val;
         logic [3:0]       steps_ff;
         logic [3:0]       group_pos;
         logic [3:0]       shift_pos;
         for (genvar i = 0; i < 64; i++) begin : g_weight
            localparam logic [63:0] WEIGHT = (64'd1 << i) % MOD64;
            assign bit_weight[i] = req_ff.key[i] ? WEIGHT[IDX_W-1:0] : '0;
         end
         assign group_pos = steps_ff - FOLD_FIRST;
         assign shift_pos = steps_ff - 4'd1;
         assign sub_val   = MOD_ACC << shift_pos[2:0];
         always_comb begin
            group_sum = '0;
            for (int b = 0; b < 8; b++) begin
               group_sum = group_sum + ACC_W'(bit_weight[{group_pos[2:0], 3'(b)}]);
            end
         end
         always_comb begin
            acc_in = acc_ff;
            if (steps_ff >= FOLD_FIRST) begin
               acc_in = acc_ff + group_sum;
            end else if (acc_ff >= sub_val) begin
               acc_in = acc_ff - sub_val;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               steps_ff <= 4'd0;
            end else if (cmd.capture) begin
               steps_ff <= STEP_COUNT;
            end else if (cmd.index_step) begin
               steps_ff <= steps_ff - 4'd1;
            end
         end
         always_ff @(posedge clock) begin
            if (cmd.capture) begin
               acc_ff <= '0;
            end else if (cmd.index_step) begin
               acc_ff <= acc_in;
            end
         end
         assign idx       = acc_ff[IDX_W-1:0];
         assign idx_ready = (steps_ff == 4'd0);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Replacement decision on the slot held in rd_ff by the lookup read.
   assign req_lock    = req_ff.key[63 -: LOCK_BITS];
   assign lock_eq     = (rd_ff.lock == req_lock);
   assign new_depth_w = {{2{req_ff.search_depth[7]}}, req_ff.search_depth};
   assign old_depth_w = {{2{rd_ff.depth[7]}}, rd_ff.depth};
   assign store_ok    = (rd_ff.lock == '0)
                     || (req_ff.bound_kind == hetr_pkg::BOUND_EXACT)
                     || (rd_ff.gen != generation_ff)
                     || ((rd_ff.bound != hetr_pkg::BOUND_EXACT) && (new_depth_w >= old_depth_w))
                     || (lock_eq && (new_depth_w + hetr_pkg::SAME_LOCK_MARGIN > old_depth_w));

   always_comb begin
      wr_entry       = '0;
      wr_addr        = clr_ff;
      mem_we         = cmd.clear_write;
      if (!cmd.clear_write) begin
         wr_addr        = idx;
         mem_we         = cmd.commit && (req_ff.mode == hetr_pkg::MODE_STORE) && store_ok;
         wr_entry.lock  = req_lock;
         wr_entry.gen   = generation_ff;
         wr_entry.depth = req_ff.search_depth;
         wr_entry.bound = req_ff.bound_kind;
         // A store without a move keeps the move already held for the same position.
         wr_entry.move  = (req_ff.move_code != 16'd0 || !lock_eq) ? req_ff.move_code
                                                                  : rd_ff.move;
         wr_entry.score = adjust_score(req_ff.score, req_ff.ply, mate_threshold_ff, 1'b1);
         wr_entry.eval  = req_ff.static_eval;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[idx];
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if ((req_ff.mode == hetr_pkg::MODE_PROBE) && lock_eq
            && (rd_ff.bound != hetr_pkg::BOUND_NONE)) begin
         rsp_data_in.hit       = 1'b1;
         rsp_data_in.hit_move  = rd_ff.move;
         rsp_data_in.hit_score = adjust_score(rd_ff.score, req_ff.ply, mate_threshold_ff, 1'b0);
         rsp_data_in.hit_eval  = rd_ff.eval;
         rsp_data_in.hit_depth = rd_ff.depth;
         rsp_data_in.hit_bound = rd_ff.bound;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign status.index_ready = idx_ready;
   assign status.clear_last  = (clr_ff == LAST_IDX);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

endmodule

// File: hw/rtl/hashed_entry_table_with_replacement_core.sv
// A word is handled in order: capture, slot index, slot read, then the commit of the
// result; for a TABLE_ENTRIES that is not a power of two the slot index takes 14 steps.
// A new word is taken only after the last one is committed; a stalled result holds
// the next word.
// Reset is synchronous; after it a clearing pass zeroes every table entry with
// req_stall high. Configuration writes are taken throughout.
module hashed_entry_table_with_replacement_core #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int LOCK_BITS     = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hetr_pkg::req_word_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hetr_pkg::rsp_word_type           rsp_data,
   input  logic                             csr_write,
   input  logic [hetr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hetr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   hetr_pkg::cmd_type    cmd;
   hetr_pkg::status_type status;

   hetr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hetr_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .LOCK_BITS     (LOCK_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: hw/rtl/hetr_checker.sv
// Port-level checks on the hashed entry table, attached to the top level by bind.
module hetr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input hetr_pkg::rsp_word_type rsp_data
);

   // A held result word stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // The table is being cleared right after reset, so no word is taken.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during the clearing pass");

   // One word is worked at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in work");

   // A miss or a store reports all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data == '0)
      else $error("miss result carries nonzero fields");

endmodule

bind hashed_entry_table_with_replacement_core hetr_checker u_checker (.*);
